// File: src/gchg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gchg_pkg
// Shared types, widths, codes and the denomination face table of the
// greedy change dispenser.
// ----------------------------------------------------------------------------
package gchg_pkg;

  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned STOCK_W  = 16;
  localparam int unsigned FACE_W   = 16;
  localparam int unsigned FIELD_W  = 24;
  localparam int unsigned QUOT_W   = 16;
  localparam int unsigned BIT_W    = 4;
  localparam int unsigned PROD_W   = 32;
  localparam int unsigned IN_DW    = 72;
  localparam int unsigned OUT_DW   = 80;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_CHANGE = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CHECK,
    ST_DIV,
    ST_MIN,
    ST_MUL,
    ST_EMIT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic emit_load;
    logic check;
    logic div_step;
    logic take_min;
    logic mul;
    logic emit_change;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic saturate;
    logic bit_zero;
    logic last_slot;
  } sts_t;

  // Face value in cents of each slot, largest first; slots past the table
  // count one cent.
  function automatic logic [FACE_W-1:0] face_of(input logic [SLOT_W-1:0] slot);
    logic [FACE_W-1:0] face;
    case (slot)
      4'd0:    face = 16'd50000;
      4'd1:    face = 16'd20000;
      4'd2:    face = 16'd10000;
      4'd3:    face = 16'd5000;
      4'd4:    face = 16'd1000;
      4'd5:    face = 16'd500;
      4'd6:    face = 16'd100;
      4'd7:    face = 16'd50;
      4'd8:    face = 16'd10;
      4'd9:    face = 16'd5;
      default: face = 16'd1;
    endcase
    return face;
  endfunction

endpackage

// File: src/gchg_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gchg_ctrl
// Sequencer that walks a load or a change item through the datapath.
// ----------------------------------------------------------------------------
module gchg_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_op_i,
  output logic            in_ready_o,
  input  gchg_pkg::sts_t  sts_i,
  output gchg_pkg::cmd_t  cmd_o
);

  gchg_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gchg_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      gchg_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          if (in_op_i == gchg_pkg::OP_LOAD) begin
            state_d = gchg_pkg::ST_LOAD;
          end else begin
            state_d = gchg_pkg::ST_CHECK;
          end
        end
      end
      gchg_pkg::ST_LOAD: begin
        if (sts_i.out_free) begin
          cmd_o.emit_load = 1'b1;
          state_d         = gchg_pkg::ST_IDLE;
        end
      end
      gchg_pkg::ST_CHECK: begin
        cmd_o.check = 1'b1;
        // A quotient beyond the count range needs no division.
        state_d = sts_i.saturate ? gchg_pkg::ST_MIN : gchg_pkg::ST_DIV;
      end
      gchg_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.bit_zero) begin
          state_d = gchg_pkg::ST_MIN;
        end
      end
      gchg_pkg::ST_MIN: begin
        cmd_o.take_min = 1'b1;
        state_d        = gchg_pkg::ST_MUL;
      end
      gchg_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = gchg_pkg::ST_EMIT;
      end
      gchg_pkg::ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_change = 1'b1;
          state_d = sts_i.last_slot ? gchg_pkg::ST_IDLE : gchg_pkg::ST_CHECK;
        end
      end
      default: begin
        state_d = gchg_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: src/gchg_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gchg_datapath
// Stock store, change register, restoring divider, multiplier and the
// output register of the greedy change dispenser.
// ----------------------------------------------------------------------------
module gchg_datapath #(
  parameter int unsigned DENOMINATIONS = 11,
  parameter int unsigned AMOUNT_BITS   = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  gchg_pkg::cmd_t                cmd_i,
  output gchg_pkg::sts_t                sts_o,
  input  logic [gchg_pkg::IN_DW-1:0]    in_data_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [gchg_pkg::OUT_DW-1:0]   out_data_o,
  output logic                          out_last_o
);

  localparam int unsigned IDX_W = (DENOMINATIONS > 1) ? $clog2(DENOMINATIONS) : 1;
  localparam int unsigned EXT_W = AMOUNT_BITS + 32;

  // Input fields.
  logic [gchg_pkg::SLOT_W-1:0]  in_idx;
  logic [gchg_pkg::STOCK_W-1:0] in_stock;
  logic [gchg_pkg::FIELD_W-1:0] in_price;
  logic [gchg_pkg::FIELD_W-1:0] in_paid;
  logic [EXT_W-1:0]             price_ext;
  logic [EXT_W-1:0]             paid_ext;
  logic [AMOUNT_BITS-1:0]       price_amt;
  logic [AMOUNT_BITS-1:0]       paid_amt;
  logic [AMOUNT_BITS-1:0]       change_init;

  assign in_idx    = in_data_i[3:0];
  assign in_stock  = in_data_i[19:4];
  assign in_price  = in_data_i[43:20];
  assign in_paid   = in_data_i[67:44];
  assign price_ext = {{(EXT_W-gchg_pkg::FIELD_W){1'b0}}, in_price};
  assign paid_ext  = {{(EXT_W-gchg_pkg::FIELD_W){1'b0}}, in_paid};
  assign price_amt = price_ext[AMOUNT_BITS-1:0];
  assign paid_amt  = paid_ext[AMOUNT_BITS-1:0];
  assign change_init = (paid_amt >= price_amt) ? (paid_amt - price_amt) : '0;

  // Working registers.
  logic [gchg_pkg::SLOT_W-1:0]  ld_idx_q;
  logic [gchg_pkg::STOCK_W-1:0] ld_val_q;
  logic [AMOUNT_BITS-1:0]       change_q;
  logic [gchg_pkg::SLOT_W-1:0]  slot_q;
  logic [31:0]                  rem_q;
  logic [gchg_pkg::QUOT_W-1:0]  quo_q;
  logic [gchg_pkg::BIT_W-1:0]   bit_q;
  logic [gchg_pkg::STOCK_W-1:0] n_q;
  logic [gchg_pkg::PROD_W-1:0]  prod_q;

  logic [gchg_pkg::STOCK_W-1:0] stock_q [DENOMINATIONS];
  logic [gchg_pkg::STOCK_W-1:0] stock_rd;
  logic [gchg_pkg::FACE_W-1:0]  face;
  logic [EXT_W-1:0]             change_ext;
  logic [EXT_W-1:0]             sat_lim;
  logic [EXT_W-1:0]             change_sub;
  logic [AMOUNT_BITS-1:0]       change_new;
  logic [EXT_W-1:0]             unpaid_ext;
  logic [31:0]                  trial;
  logic                         ld_in_range;
  logic                         last_slot;

  assign stock_rd   = stock_q[slot_q[IDX_W-1:0]];
  assign face       = gchg_pkg::face_of(slot_q);
  assign change_ext = {32'b0, change_q};
  assign sat_lim    = {{AMOUNT_BITS{1'b0}}, face, 16'b0};
  assign trial      = {16'b0, face} << bit_q;
  assign change_sub = change_ext - {{AMOUNT_BITS{1'b0}}, prod_q};
  assign change_new = change_sub[AMOUNT_BITS-1:0];
  assign unpaid_ext = {32'b0, change_new};
  assign ld_in_range = ({1'b0, ld_idx_q} < (gchg_pkg::SLOT_W + 1)'(DENOMINATIONS));
  assign last_slot  = (slot_q == gchg_pkg::SLOT_W'(DENOMINATIONS - 1));

  // Output register.
  logic                          out_valid_q;
  logic [gchg_pkg::OUT_DW-1:0]   out_data_q;
  logic                          out_last_q;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;

  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign sts_o.saturate  = (change_ext >= sat_lim);
  assign sts_o.bit_zero  = (bit_q == '0);
  assign sts_o.last_slot = last_slot;

  // Stock store, cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DENOMINATIONS; i++) begin
        stock_q[i] <= '0;
      end
    end else if (cmd_i.emit_load && ld_in_range) begin
      stock_q[ld_idx_q[IDX_W-1:0]] <= ld_val_q;
    end else if (cmd_i.emit_change) begin
      stock_q[slot_q[IDX_W-1:0]] <= stock_rd - n_q;
    end
  end

  // Item registers, divider and multiplier.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      ld_idx_q <= in_idx;
      ld_val_q <= in_stock;
      change_q <= change_init;
      slot_q   <= '0;
    end
    if (cmd_i.check) begin
      bit_q <= '1;
      if (sts_o.saturate) begin
        quo_q <= '1;
      end else begin
        quo_q <= '0;
        rem_q <= change_ext[31:0];
      end
    end
    if (cmd_i.div_step) begin
      bit_q <= bit_q - 1'b1;
      if (rem_q >= trial) begin
        rem_q        <= rem_q - trial;
        quo_q[bit_q] <= 1'b1;
      end
    end
    if (cmd_i.take_min) begin
      n_q <= (quo_q < stock_rd) ? quo_q : stock_rd;
    end
    if (cmd_i.mul) begin
      prod_q <= n_q * face;
    end
    if (cmd_i.emit_change) begin
      change_q <= change_new;
      slot_q   <= slot_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_load || cmd_i.emit_change) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_load) begin
      out_last_q <= 1'b1;
      out_data_q <= {4'b0,
                     24'b0,
                     ld_in_range ? ld_val_q : 16'b0,
                     16'b0,
                     ld_in_range ? gchg_pkg::face_of(ld_idx_q) : 16'b0,
                     ld_idx_q};
    end else if (cmd_i.emit_change) begin
      out_last_q <= last_slot;
      out_data_q <= {4'b0,
                     last_slot ? unpaid_ext[gchg_pkg::FIELD_W-1:0] : 24'b0,
                     stock_rd - n_q,
                     n_q,
                     face,
                     slot_q};
    end
  end

endmodule

// File: src/greedy_change_dispenser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_change_dispenser
// Change dispenser with a limited stock per denomination, greedy payout.
// ----------------------------------------------------------------------------
// The block keeps a 16-bit stock count for each denomination slot, slot 0
// being 500.00 and slot 10 being 0.01, all amounts in integer cents; reset
// clears every count. A load item (tuser low) sets one slot's stock and
// gives one result item. A change item (tuser high) takes paid minus price
// and walks the slots from the largest face down, handing out as many
// pieces as the remaining change covers and the stock allows; it gives one
// result item per slot, and the last one (tlast high) carries the change
// that could not be paid. When paid is below price nothing is handed out.
// One item is worked on at a time. A change works each slot in turn: a
// check, the restoring divider, which produces one quotient bit per
// cycle, a clamp to the stock, a multiply and the result; a slot whose
// count would overflow 16 bits skips the divider. A new item is accepted
// while the final result of the previous one still waits in the output
// register.
module greedy_change_dispenser #(
  parameter int unsigned DENOMINATIONS = 11,
  parameter int unsigned AMOUNT_BITS   = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input items.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata from bit 0: denom_index[3:0], stock_value[19:4],
  // price_cents[43:20], paid_cents[67:44], zero fill to bit 71.
  input  logic [71:0] s_axis_tdata,
  // tuser: operation, 0 is load stock and 1 is make change.
  input  logic        s_axis_tuser,
  // Result items.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata from bit 0: slot[3:0], face_cents[19:4], dispensed[35:20],
  // stock_left[51:36], unpaid_cents[75:52], zero fill to bit 79.
  output logic [79:0] m_axis_tdata,
  // tlast: high on the final result of an item.
  output logic        m_axis_tlast
);

  gchg_pkg::cmd_t cmd;
  gchg_pkg::sts_t sts;

  gchg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_op_i    (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gchg_datapath #(
    .DENOMINATIONS (DENOMINATIONS),
    .AMOUNT_BITS   (AMOUNT_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (s_axis_tdata),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the greedy change dispenser.
// ----------------------------------------------------------------------------
// Load and change items go into the input stream from a queue. A model of the
// per-slot stock predicts every result item, and the output stream is checked
// against that prediction field by field. The sender works in random bursts
// and the receiver stalls in several patterns that change during the run.
module tb;

  localparam int unsigned NUM_SLOTS      = 11;
  localparam int unsigned RANDOM_ITEMS   = 360;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned DRAIN_CYCLES   = 250;
  localparam logic [23:0] AMOUNT_MAX     = 24'hFFFFFF;

  localparam logic [15:0] FACE_CENTS [NUM_SLOTS] = '{
    16'd50000, 16'd20000, 16'd10000, 16'd5000, 16'd1000, 16'd500,
    16'd100, 16'd50, 16'd10, 16'd5, 16'd1
  };

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_MOSTLY,
    RDY_RARELY,
    RDY_PERIODIC
  } ready_mode_e;

  typedef struct packed {
    gchg_pkg::op_e op;
    logic [3:0]    denom;
    logic [15:0]   stock;
    logic [23:0]   price;
    logic [23:0]   paid;
  } request_t;

  typedef struct packed {
    logic [3:0]  slot;
    logic [15:0] face;
    logic [15:0] dispensed;
    logic [15:0] stock_left;
    logic [23:0] unpaid;
    logic        last;
  } payout_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic        m_axis_tlast;

  request_t    request_q [$];
  payout_t     payout_q [$];
  logic [15:0] stock_model [NUM_SLOTS];
  request_t    on_bus;
  logic        in_fire     = 1'b0;
  bit          failed      = 1'b0;
  int unsigned burst_left  = 1;
  int unsigned gap_left    = 0;
  int unsigned idle_cycles = 0;
  int unsigned ready_tick  = 0;
  ready_mode_e ready_mode  = RDY_ALWAYS;

  greedy_change_dispenser dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #10 clk_i = ~clk_i;

  // Works out the result items of one accepted item and updates the stock.
  task automatic predict_payout(input request_t req);
    payout_t     r;
    logic [23:0] owed;
    logic [23:0] pieces;
    logic        pay_ok;
    int unsigned s;
    r = '0;
    if (req.op == gchg_pkg::OP_LOAD) begin
      r.slot = req.denom;
      r.last = 1'b1;
      if (req.denom < NUM_SLOTS) begin
        stock_model[req.denom] = req.stock;
        r.face       = FACE_CENTS[req.denom];
        r.stock_left = req.stock;
      end
      payout_q.insert(payout_q.size(), r);
    end else begin
      pay_ok = (req.paid >= req.price);
      owed   = pay_ok ? req.paid - req.price : 24'd0;
      for (s = 0; s < NUM_SLOTS; s++) begin
        pieces = '0;
        if (pay_ok) begin
          pieces = owed / FACE_CENTS[s];
          if (pieces > stock_model[s]) begin
            pieces = {8'd0, stock_model[s]};
          end
          owed = owed - pieces * FACE_CENTS[s];
          stock_model[s] = stock_model[s] - pieces[15:0];
        end
        r.slot       = s[3:0];
        r.face       = FACE_CENTS[s];
        r.dispensed  = pieces[15:0];
        r.stock_left = stock_model[s];
        r.last       = (s == NUM_SLOTS - 1);
        r.unpaid     = r.last ? owed : 24'd0;
        payout_q.insert(payout_q.size(), r);
      end
    end
  endtask

  task automatic report_field(input string name, input logic [23:0] exp_v,
                              input logic [23:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      failed = 1'b1;
    end
  endtask

  task automatic add_load(input logic [3:0] denom, input logic [15:0] stock);
    request_t req;
    req       = {gchg_pkg::OP_LOAD, 68'd0};
    req.denom = denom;
    req.stock = stock;
    req.price = 24'($urandom_range(0, AMOUNT_MAX));
    req.paid  = 24'($urandom_range(0, AMOUNT_MAX));
    request_q.insert(request_q.size(), req);
  endtask

  task automatic add_change(input logic [23:0] price, input logic [23:0] paid);
    request_t req;
    req       = {gchg_pkg::OP_CHANGE, 68'd0};
    req.denom = 4'($urandom_range(0, 15));
    req.stock = 16'($urandom_range(0, 65535));
    req.price = price;
    req.paid  = paid;
    request_q.insert(request_q.size(), req);
  endtask

  // Sender: bursts of items with random gaps, bus changes at the falling edge.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_fire) begin
      if (gap_left == 0 && request_q.size() != 0) begin
        on_bus = request_q.pop_front();
        s_axis_tdata  <= {4'b0, on_bus.paid, on_bus.price, on_bus.stock, on_bus.denom};
        s_axis_tuser  <= on_bus.op;
        s_axis_tvalid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 8);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
        end
      end else begin
        if (gap_left != 0) begin
          gap_left--;
        end
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: the stall pattern is picked anew at random during the run.
  always @(negedge clk_i) begin
    ready_tick++;
    if (ready_tick % 600 == 0) begin
      ready_mode = ready_mode_e'($urandom_range(0, 3));
    end
    case (ready_mode)
      RDY_ALWAYS:   m_axis_tready <= 1'b1;
      RDY_MOSTLY:   m_axis_tready <= ($urandom_range(0, 3) != 0);
      RDY_RARELY:   m_axis_tready <= ($urandom_range(0, 4) == 0);
      default:      m_axis_tready <= (ready_tick[3:0] < 4'd11);
    endcase
  end

  // Acceptance on both sides, result checking and the watchdog.
  always @(posedge clk_i) begin
    payout_t act;
    payout_t exp_r;
    if (!rst_ni) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        predict_payout(on_bus);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        act.slot       = m_axis_tdata[3:0];
        act.face       = m_axis_tdata[19:4];
        act.dispensed  = m_axis_tdata[35:20];
        act.stock_left = m_axis_tdata[51:36];
        act.unpaid     = m_axis_tdata[75:52];
        act.last       = m_axis_tlast;
        if (payout_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, act);
          failed = 1'b1;
        end else begin
          exp_r = payout_q.pop_front();
          report_field("slot", 24'(exp_r.slot), 24'(act.slot));
          report_field("face_cents", 24'(exp_r.face), 24'(act.face));
          report_field("dispensed", 24'(exp_r.dispensed), 24'(act.dispensed));
          report_field("stock_left", 24'(exp_r.stock_left), 24'(act.stock_left));
          report_field("unpaid_cents", exp_r.unpaid, act.unpaid);
          report_field("last", 24'(exp_r.last), 24'(act.last));
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("tb failed");
          $finish;
        end
      end
    end
  end

  initial begin
    int unsigned n;
    int unsigned pick;
    int unsigned kind;
    logic [23:0] chg;
    logic [23:0] price;
    for (n = 0; n < NUM_SLOTS; n++) begin
      stock_model[n] = '0;
    end

    // Directed: empty stock, the quotient overflow on the one-cent slot,
    // every slot loaded, loads out of range, paid below price, zero change.
    add_change(24'd100, 24'd12345);
    add_load(4'd10, 16'hFFFF);
    add_change(24'd0, AMOUNT_MAX);
    add_load(4'd0, 16'hFFFF);
    add_load(4'd1, 16'd0);
    add_load(4'd2, 16'd5);
    add_load(4'd3, 16'd2);
    add_load(4'd4, 16'd7);
    add_load(4'd5, 16'd1);
    add_load(4'd6, 16'd9);
    add_load(4'd7, 16'd4);
    add_load(4'd8, 16'd30);
    add_load(4'd9, 16'hFFFF);
    add_load(4'd10, 16'd40000);
    add_load(4'd11, 16'hFFFF);
    add_load(4'd15, 16'hAAAA);
    add_change(AMOUNT_MAX, 24'd0);
    add_change(AMOUNT_MAX, AMOUNT_MAX);
    add_change(24'd1, 24'd88889);
    add_change(24'd0, AMOUNT_MAX);
    add_change(24'd12345, 24'd12344);
    add_change(24'd5, 24'h800004);

    // Random: loads of mostly small stock mixed with mostly payable changes.
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        add_load(4'((pick < 2) ? $urandom_range(11, 15) : $urandom_range(0, 10)),
                 16'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                                 : $urandom_range(0, 12)));
      end else begin
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
          add_change(24'($urandom_range(0, AMOUNT_MAX)),
                     24'($urandom_range(0, AMOUNT_MAX)));
        end else if (kind == 1) begin
          price = 24'($urandom_range(1, AMOUNT_MAX));
          add_change(price, 24'($urandom_range(0, price - 1)));
        end else begin
          if (kind < 6) begin
            chg = 24'($urandom_range(0, 20000));
          end else if (kind < 9) begin
            chg = 24'($urandom_range(0, 1000000));
          end else begin
            chg = 24'($urandom_range(0, AMOUNT_MAX));
          end
          price = 24'($urandom_range(0, AMOUNT_MAX - chg));
          add_change(price, price + chg);
        end
      end
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (request_q.size() != 0 || s_axis_tvalid || payout_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (!failed) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
